// File: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is quiet while reset is asserted.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("checker: property failed");

// Concurrent assertion that is checked in and out of reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("checker: property failed");

`endif

// File: src/ctsf_pkg.sv
// Shared widths, codes and types of the cascaded smoothing track filter.
package ctsf_pkg;

  localparam int DATA_W     = 32;
  localparam int GAIN_W     = 16;
  localparam int IPER_W     = 24;
  localparam int SAMPLE_W   = 20;
  localparam int TRACK_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int IN_DATA_W  = 2 * SAMPLE_W;
  localparam int IN_USER_W  = TRACK_W + 1;
  localparam int OUT_DATA_W = 6 * DATA_W;
  localparam int OUT_USER_W = TRACK_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_GAIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_PER  = 2'd3;

  localparam logic [GAIN_W-1:0] GAIN_RESET    = 16'd32768;
  localparam logic [IPER_W-1:0] INV_PER_RESET = 24'd1310720;

  // Steps of one axis: smooth position, derive, smooth velocity, derive, smooth accel
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_POS   = 3'd0;
  localparam logic [OP_W-1:0] OP_VEL_D = 3'd1;
  localparam logic [OP_W-1:0] OP_VEL   = 3'd2;
  localparam logic [OP_W-1:0] OP_ACC_D = 3'd3;
  localparam logic [OP_W-1:0] OP_ACC   = 3'd4;

  typedef struct packed {
    logic                 load;
    logic                 seed;
    logic                 ops_en;
    logic                 mul_en;
    logic                 post_en;
    logic [OP_W-1:0]      op;
  } lane_ctrl_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] acc;
    logic signed [DATA_W-1:0] vel;
    logic signed [DATA_W-1:0] pos;
  } lane_state_t;

endpackage

// File: src/ctsf_ram.sv
// Generic single-port-write, registered-read RAM.
module ctsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/ctsf_lane.sv
// One axis lane: three cascaded smoothers on a shared multiplier.
module ctsf_lane import ctsf_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                        clk_i,
  input  lane_ctrl_t                  ctrl_i,
  input  logic signed [SAMPLE_W-1:0]  sample_i,
  input  lane_state_t                 old_i,
  input  logic [GAIN_W-1:0]           pos_gain_i,
  input  logic [GAIN_W-1:0]           vel_gain_i,
  input  logic [GAIN_W-1:0]           acc_gain_i,
  input  logic [IPER_W-1:0]           inv_period_i,
  output lane_state_t                 res_o
);

  localparam int DIFF_W  = DATA_W + 1;
  localparam int MULB_W  = IPER_W + 1;
  localparam int PROD_W  = DIFF_W + MULB_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int SHIFT_W = SUM_W - GAIN_W;
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (GAIN_W - 1);

  function automatic logic signed [DATA_W-1:0] sat_data(
    input logic signed [SHIFT_W-1:0] v
  );
    if (&v[SHIFT_W-1:DATA_W-1] || ~|v[SHIFT_W-1:DATA_W-1]) begin
      return v[DATA_W-1:0];
    end else if (v[SHIFT_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  logic signed [SHIFT_W-1:0] sx_wide;
  logic signed [DATA_W-1:0]  sx;
  logic signed [DATA_W-1:0]  p0_q, v0_q, a0_q;
  logic signed [DATA_W-1:0]  np_q, nv_q, na_q;
  logic signed [DATA_W-1:0]  r_q;
  logic signed [DIFF_W-1:0]  opa_d, opa_q;
  logic signed [MULB_W-1:0]  opb_d, opb_q;
  logic signed [DATA_W-1:0]  in_d, in_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [SUM_W-1:0]   sum;
  logic signed [DATA_W-1:0]  post_res;

  assign sx_wide = SHIFT_W'(sample_i) <<< FRACTION_BITS;
  assign sx      = sat_data(sx_wide);

  // Smooth: in*2^16 + g*(old - in). Derive: (new - old) * inverse period.
  always_comb begin
    opa_d = '0;
    opb_d = '0;
    in_d  = '0;
    case (ctrl_i.op)
      OP_POS: begin
        opa_d = DIFF_W'(p0_q) - DIFF_W'(sx);
        opb_d = $signed({{(MULB_W-GAIN_W){1'b0}}, pos_gain_i});
        in_d  = sx;
      end
      OP_VEL_D: begin
        opa_d = DIFF_W'(np_q) - DIFF_W'(p0_q);
        opb_d = $signed({1'b0, inv_period_i});
      end
      OP_VEL: begin
        opa_d = DIFF_W'(v0_q) - DIFF_W'(r_q);
        opb_d = $signed({{(MULB_W-GAIN_W){1'b0}}, vel_gain_i});
        in_d  = r_q;
      end
      OP_ACC_D: begin
        opa_d = DIFF_W'(nv_q) - DIFF_W'(v0_q);
        opb_d = $signed({1'b0, inv_period_i});
      end
      OP_ACC: begin
        opa_d = DIFF_W'(a0_q) - DIFF_W'(r_q);
        opb_d = $signed({{(MULB_W-GAIN_W){1'b0}}, acc_gain_i});
        in_d  = r_q;
      end
      default: begin
      end
    endcase
  end

  // Round half up, drop 16 fraction bits, saturate
  assign sum      = SUM_W'(prod_q) + (SUM_W'(in_q) <<< GAIN_W) + HALF;
  assign post_res = sat_data(sum[SUM_W-1:GAIN_W]);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      p0_q <= ctrl_i.seed ? sx : old_i.pos;
      v0_q <= old_i.vel;
      a0_q <= old_i.acc;
    end
    if (ctrl_i.ops_en) begin
      opa_q <= opa_d;
      opb_q <= opb_d;
      in_q  <= in_d;
    end
    if (ctrl_i.mul_en) begin
      prod_q <= PROD_W'(opa_q) * PROD_W'(opb_q);
    end
    if (ctrl_i.post_en) begin
      r_q <= post_res;
      case (ctrl_i.op)
        OP_POS:  np_q <= post_res;
        OP_VEL:  nv_q <= post_res;
        OP_ACC:  na_q <= post_res;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_o.pos = np_q;
    res_o.vel = nv_q;
    res_o.acc = na_q;
  end

endmodule

// File: src/cascaded_smoothing_track_filter.sv
// Top level: per-track state, sequencer, x/y lanes and result merge register.
// A word passes the state read, the five steps and the merge register before its result is valid.
// Input is taken only in idle; the five dependent steps per axis each pass operand select,
//   the lane's single multiplier and round/saturate in turn.
// A finished result waits in the output register while the next word is accepted and worked on.
// Reset: control, valid bits and configuration (gains 0.5, inverse period 20.0) clear at once;
//   tracks read as zero until written, no clearing pass.
module cascaded_smoothing_track_filter import ctsf_pkg::*; #(
  parameter int TRACKS        = 4,
  parameter int FRACTION_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // sample_x, sample_y
  input  logic [IN_USER_W-1:0]   s_axis_tuser,   // track, restart
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // pos_x, pos_y, vel_x, vel_y, acc_x, acc_y
  output logic [OUT_USER_W-1:0]  m_axis_tuser    // track_out
);

  localparam int IDX_W = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int TMW   = TRACK_W + 1;
  localparam logic [TMW-1:0] TRK_STEP = TMW'(TRACKS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_OPS  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_POST = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [OP_W-1:0]      op_q, op_d;

  logic [GAIN_W-1:0]    pos_gain_q, vel_gain_q, acc_gain_q;
  logic [IPER_W-1:0]    inv_period_q;

  logic [TRACK_W-1:0]   track_q;
  logic                 restart_q;
  logic signed [SAMPLE_W-1:0] sample_x_q, sample_y_q;
  logic [IDX_W-1:0]     idx_q;
  logic [TMW-1:0]       trk_mod;
  logic [IDX_W-1:0]     rd_addr;
  logic [TRACKS-1:0]    valid_q;

  logic                 s_acc;
  logic                 out_load;
  logic                 out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [OUT_USER_W-1:0] out_user_q;

  lane_state_t          ram_x, ram_y;
  lane_state_t          old_x, old_y;
  lane_state_t          res_x, res_y;
  lane_ctrl_t           ctrl;
  logic                 entry_live;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // Fold the track number onto the state entries
  always_comb begin
    trk_mod = {1'b0, s_axis_tuser[TRACK_W-1:0]};
    for (int k = 0; k < 3; k++) begin
      if (int'(trk_mod) >= TRACKS) begin
        trk_mod = trk_mod - TRK_STEP;
      end
    end
  end
  assign rd_addr = IDX_W'(trk_mod);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_gain_q   <= GAIN_RESET;
      vel_gain_q   <= GAIN_RESET;
      acc_gain_q   <= GAIN_RESET;
      inv_period_q <= INV_PER_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POS_GAIN: pos_gain_q   <= cfg_wdata_i[GAIN_W-1:0];
        REG_VEL_GAIN: vel_gain_q   <= cfg_wdata_i[GAIN_W-1:0];
        REG_ACC_GAIN: acc_gain_q   <= cfg_wdata_i[GAIN_W-1:0];
        REG_INV_PER:  inv_period_q <= cfg_wdata_i[IPER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Hold the accepted word while the lanes work on it
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      track_q    <= s_axis_tuser[TRACK_W-1:0];
      restart_q  <= s_axis_tuser[TRACK_W];
      sample_x_q <= s_axis_tdata[SAMPLE_W-1:0];
      sample_y_q <= s_axis_tdata[IN_DATA_W-1:SAMPLE_W];
      idx_q      <= rd_addr;
    end
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        op_d    = OP_POS;
        state_d = ST_OPS;
      end
      ST_OPS: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_POST;
      end
      ST_POST: begin
        state_d = ST_OPS;
        case (op_q)
          OP_POS:   op_d = OP_VEL_D;
          OP_VEL_D: op_d = OP_VEL;
          OP_VEL:   op_d = OP_ACC_D;
          OP_ACC_D: op_d = OP_ACC;
          default:  state_d = ST_DONE;
        endcase
      end
      ST_DONE: begin
        // merge both lanes once the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_POS;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      if (out_load) begin
        valid_q[idx_q] <= 1'b1;
        out_valid_q    <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Never-written or restarted tracks read as zero; zero position on both axes seeds
  assign entry_live = valid_q[idx_q] && !restart_q;
  assign old_x      = entry_live ? ram_x : '0;
  assign old_y      = entry_live ? ram_y : '0;

  always_comb begin
    ctrl         = '0;
    ctrl.load    = (state_q == ST_LOAD);
    ctrl.seed    = (old_x.pos == '0) && (old_y.pos == '0);
    ctrl.ops_en  = (state_q == ST_OPS);
    ctrl.mul_en  = (state_q == ST_MUL);
    ctrl.post_en = (state_q == ST_POST);
    ctrl.op      = op_q;
  end

  ctsf_ram #(
    .WIDTH ($bits(lane_state_t)),
    .DEPTH (TRACKS)
  ) u_ram_x (
    .clk_i   (clk_i),
    .we_i    (out_load),
    .waddr_i (idx_q),
    .wdata_i (res_x),
    .raddr_i (rd_addr),
    .rdata_o (ram_x)
  );

  ctsf_ram #(
    .WIDTH ($bits(lane_state_t)),
    .DEPTH (TRACKS)
  ) u_ram_y (
    .clk_i   (clk_i),
    .we_i    (out_load),
    .waddr_i (idx_q),
    .wdata_i (res_y),
    .raddr_i (rd_addr),
    .rdata_o (ram_y)
  );

  ctsf_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_x (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .sample_i     (sample_x_q),
    .old_i        (old_x),
    .pos_gain_i   (pos_gain_q),
    .vel_gain_i   (vel_gain_q),
    .acc_gain_i   (acc_gain_q),
    .inv_period_i (inv_period_q),
    .res_o        (res_x)
  );

  ctsf_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_y (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .sample_i     (sample_y_q),
    .old_i        (old_y),
    .pos_gain_i   (pos_gain_q),
    .vel_gain_i   (vel_gain_q),
    .acc_gain_i   (acc_gain_q),
    .inv_period_i (inv_period_q),
    .res_o        (res_y)
  );

  // Merge register: interleave the two lanes into one result word
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {res_y.acc, res_x.acc, res_y.vel, res_x.vel, res_y.pos, res_x.pos};
      out_user_q <= track_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// File: src/ctsf_checker.sv
// Port-level checker for the cascaded smoothing track filter, with its bind.
`include "assert_macros.svh"

module ctsf_checker import ctsf_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [OUT_USER_W-1:0] m_axis_tuser
);

  logic s_acc;
  logic out_stall;
  logic [OUT_USER_W+OUT_DATA_W-1:0] out_word;

  assign s_acc     = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_word  = {m_axis_tuser, m_axis_tdata};

  // a stalled result word holds
  `ASSERT_RST(a_out_hold, clk_i, rst_ni, out_stall |=> m_axis_tvalid && $stable(out_word))
  // one word at a time: input stays closed while the lanes work
  `ASSERT_RST(a_busy_after_accept, clk_i, rst_ni, s_acc |=> !s_axis_tready ##1 !s_axis_tready)
  // a result never appears the cycle after a word is taken in
  `ASSERT_RST(a_no_early_result, clk_i, rst_ni, s_acc |=> !$rose(m_axis_tvalid))
  // reset keeps the output valid low from the next edge on
  `ASSERT_ALWAYS(a_reset_clears_out, clk_i, !rst_ni |=> !m_axis_tvalid)

endmodule

bind cascaded_smoothing_track_filter ctsf_checker u_checker (.*);

// File: tb/sv/tb.sv
// Self-checking testbench for the cascaded smoothing track filter.
`timescale 1ns / 100ps

module tb;
  import ctsf_pkg::*;

  localparam int NUM_TRACKS  = 4;
  localparam int FRAC_BITS   = 8;
  localparam int MAX_IDLE    = 19;
  localparam int DRAIN       = 24;     // a margin beyond the accept-to-result latency
  localparam int HOLD_CYCLES = 400;    // long receiver hold-off to back up the input
  localparam int PHASES      = 12;
  localparam int PHASE_WORDS = 152;

  // One filtered result: track echo plus the six packed Q.8 values.
  typedef struct {
    logic [OUT_USER_W-1:0] trk;
    logic [OUT_DATA_W-1:0] data;
  } track_result_t;

  // Tracks the filter state per track and checks each result word in order.
  class track_filter_model;
    int                    pos_st[NUM_TRACKS][2];
    int                    vel_st[NUM_TRACKS][2];
    int                    acc_st[NUM_TRACKS][2];
    logic [GAIN_W-1:0]     pos_gain;
    logic [GAIN_W-1:0]     vel_gain;
    logic [GAIN_W-1:0]     acc_gain;
    logic [IPER_W-1:0]     inv_period;
    track_result_t         expected_q[$];
    int                    errors;
    int                    checked;

    function new();
      foreach (pos_st[t, a]) begin
        pos_st[t][a] = 0;
        vel_st[t][a] = 0;
        acc_st[t][a] = 0;
      end
      pos_gain   = GAIN_RESET;
      vel_gain   = GAIN_RESET;
      acc_gain   = GAIN_RESET;
      inv_period = INV_PER_RESET;
      errors     = 0;
      checked    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_POS_GAIN: pos_gain   = val[GAIN_W-1:0];
        REG_VEL_GAIN: vel_gain   = val[GAIN_W-1:0];
        REG_ACC_GAIN: acc_gain   = val[GAIN_W-1:0];
        REG_INV_PER:  inv_period = val[IPER_W-1:0];
        default: ;
      endcase
    endfunction

    function int sat32(longint v);
      if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
      if (v < -longint'(64'sh8000_0000)) return 32'sh8000_0000;
      return int'(v);
    endfunction

    // add one half, then floor-divide by 2^16
    function longint round16(longint v);
      return (v + 64'sd32768) >>> 16;
    endfunction

    function int smooth(logic [GAIN_W-1:0] gain, int old, int din);
      longint sum;
      sum = longint'(gain) * longint'(old) + (64'sd65536 - longint'(gain)) * longint'(din);
      return sat32(round16(sum));
    endfunction

    function int derive(int now, int prev);
      longint diff;
      diff = longint'(now) - longint'(prev);
      return sat32(round16(diff * longint'(inv_period)));
    endfunction

    function void note_sample(logic [TRACK_W-1:0] trk, logic restart,
                              logic [SAMPLE_W-1:0] sx, logic [SAMPLE_W-1:0] sy);
      int            t;
      int            smp[2];
      int            np;
      int            nv;
      int            na;
      track_result_t r;
      t      = int'(trk) % NUM_TRACKS;
      smp[0] = sat32(longint'(signed'(sx)) * (64'sd1 << FRAC_BITS));
      smp[1] = sat32(longint'(signed'(sy)) * (64'sd1 << FRAC_BITS));
      if (restart) begin
        for (int a = 0; a < 2; a++) begin
          pos_st[t][a] = 0;
          vel_st[t][a] = 0;
          acc_st[t][a] = 0;
        end
      end
      // an all-zero position means the track is fresh: seed it
      if (pos_st[t][0] == 0 && pos_st[t][1] == 0) begin
        pos_st[t][0] = smp[0];
        pos_st[t][1] = smp[1];
      end
      for (int a = 0; a < 2; a++) begin
        np = smooth(pos_gain, pos_st[t][a], smp[a]);
        nv = smooth(vel_gain, vel_st[t][a], derive(np, pos_st[t][a]));
        na = smooth(acc_gain, acc_st[t][a], derive(nv, vel_st[t][a]));
        pos_st[t][a] = np;
        vel_st[t][a] = nv;
        acc_st[t][a] = na;
      end
      r.trk  = trk;
      r.data = {acc_st[t][1], acc_st[t][0], vel_st[t][1], vel_st[t][0],
                pos_st[t][1], pos_st[t][0]};
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [OUT_USER_W-1:0] trk, logic [OUT_DATA_W-1:0] data);
      string         names[6];
      track_result_t r;
      logic [31:0]   want;
      logic [31:0]   got;
      names = '{"pos_x", "pos_y", "vel_x", "vel_y", "acc_x", "acc_y"};
      if (expected_q.size() == 0) begin
        $error("result word for track %0d with no sample pending", trk);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      checked++;
      if (trk !== r.trk) begin
        $error("track_out: expected %0d, actual %0d", r.trk, trk);
        errors++;
      end
      for (int i = 0; i < 6; i++) begin
        want = r.data[i*32 +: 32];
        got  = data[i*32 +: 32];
        if (got !== want) begin
          $error("%s: expected %0d, actual %0d", names[i], $signed(want), $signed(got));
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // Clock, reset and every block input start at known values.
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = REG_POS_GAIN;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // sample_x, sample_y
  logic [IN_USER_W-1:0]  s_axis_tuser  = '0;   // track, restart
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // pos_x, pos_y, vel_x, vel_y, acc_x, acc_y
  logic [OUT_USER_W-1:0] m_axis_tuser;         // track_out

  track_filter_model model = new();

  // Idle switches per phase; a cleared switch gives a stretch with no gaps.
  bit tx_idle      = 1'b0;
  bit rx_idle      = 1'b0;
  bit hold_off_req = 1'b0;
  int holds_done   = 0;
  int words_sent   = 0;
  int settings     = 0;

  // Trajectory state for well-formed motion per track and axis.
  int path_pos[NUM_TRACKS][2];
  int path_vel[NUM_TRACKS][2];

  cascaded_smoothing_track_filter #(
    .TRACKS        (NUM_TRACKS),
    .FRACTION_BITS (FRAC_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Offer one sample word. Valid stays high after the accept so that a
  // back-to-back word only changes data; lower it only before a gap.
  task automatic offer_sample(logic [TRACK_W-1:0] trk, logic restart,
                              logic [SAMPLE_W-1:0] sx, logic [SAMPLE_W-1:0] sy);
    int gap;
    gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {sy, sx};
    s_axis_tuser  <= {restart, trk};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    model.note_sample(trk, restart, sx, sy);
    words_sent++;
  endtask

  // Drop valid, wait for every pending result, then let the pipeline run dry.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (model.pending() > 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // One register write; the idle edge after it keeps the enable single-driven.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    model.set_reg(idx, val);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(logic [CFG_DATA_W-1:0] pg, logic [CFG_DATA_W-1:0] vg,
                           logic [CFG_DATA_W-1:0] ag, logic [CFG_DATA_W-1:0] ip);
    write_reg(REG_POS_GAIN, pg);
    write_reg(REG_VEL_GAIN, vg);
    write_reg(REG_ACC_GAIN, ag);
    write_reg(REG_INV_PER, ip);
    settings++;
  endtask

  // Gains are mostly random, sometimes pinned at an end. Upper bits of the
  // write data are random so that truncation to 16 bits is exercised.
  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    int k;
    k = $urandom_range(0, 99);
    if (k < 12) return {8'($urandom), 16'h0000};
    if (k < 24) return {8'($urandom), 16'hFFFF};
    return 24'($urandom);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_inv_period();
    int k;
    k = $urandom_range(0, 99);
    if (k < 8)  return 24'd1;
    if (k < 14) return 24'hFF_FFFF;
    if (k < 18) return 24'd0;
    if (k < 30) return 24'($urandom);
    // realistic update rates: about 1/16 Hz up to 128 Hz
    return 24'($urandom_range(32'h1000, 32'h80_0000));
  endfunction

  // Mostly smooth motion with random content; the rest is wide noise,
  // near-zero jitter and the occasional restart.
  task automatic random_sample();
    int                  trk;
    int                  k;
    logic                restart;
    logic [SAMPLE_W-1:0] s[2];
    trk     = $urandom_range(0, NUM_TRACKS - 1);
    restart = ($urandom_range(0, 24) == 0);
    k       = $urandom_range(0, 99);
    for (int a = 0; a < 2; a++) begin
      if (k < 75) begin
        if ($urandom_range(0, 15) == 0) path_vel[trk][a] = $urandom_range(0, 800) - 400;
        path_pos[trk][a] += path_vel[trk][a] + $urandom_range(0, 16) - 8;
        if (path_pos[trk][a] > 524287 || path_pos[trk][a] < -524288) begin
          path_pos[trk][a] = $urandom_range(0, 4000) - 2000;
          path_vel[trk][a] = -path_vel[trk][a];
        end
        s[a] = path_pos[trk][a][SAMPLE_W-1:0];
      end else if (k < 90) begin
        s[a] = SAMPLE_W'($urandom);
      end else begin
        s[a] = SAMPLE_W'($urandom_range(0, 32) - 16);
      end
    end
    offer_sample(TRACK_W'(trk), restart, s[0], s[1]);
  endtask

  // Result side: stall at random, or hold off for a long stretch on request.
  initial begin
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
        holds_done++;
      end else if (rx_idle) begin
        int stall;
        stall = $urandom_range(0, MAX_IDLE);
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      model.check_result(m_axis_tuser, m_axis_tdata);
    end
  end

  // Stimulus: directed corners first, then random phases.
  initial begin
    int mode;
    foreach (path_pos[t, a]) begin
      path_pos[t][a] = $urandom_range(0, 20000) - 10000;
      path_vel[t][a] = $urandom_range(0, 200) - 100;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: seeding at the sample extremes, then full-scale swings
    // that drive velocity and acceleration into saturation.
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    offer_sample(2'd0, 1'b0, 20'h7FFFF, 20'h80000);
    offer_sample(2'd0, 1'b0, 20'h80000, 20'h7FFFF);
    offer_sample(2'd0, 1'b0, 20'h7FFFF, 20'h80000);
    // a zero sample leaves the track unseeded; the next one seeds it
    offer_sample(2'd1, 1'b0, 20'h00000, 20'h00000);
    offer_sample(2'd1, 1'b0, 20'h00005, 20'hFFFFD);
    offer_sample(2'd1, 1'b0, 20'h0000A, 20'hFFFFA);
    // restart clears the saturated track and reseeds it
    offer_sample(2'd0, 1'b1, 20'h00064, 20'h000C8);
    offer_sample(2'd2, 1'b0, 20'h003E8, 20'hFFC18);
    offer_sample(2'd3, 1'b0, 20'hFFFFF, 20'h00001);
    offer_sample(2'd2, 1'b0, 20'h003F2, 20'hFFC22);
    offer_sample(2'd3, 1'b1, 20'h00000, 20'h00000);
    settle();

    // Zero gains pass the input straight through; largest inverse period.
    write_all(24'h000000, 24'h000000, 24'h000000, 24'hFF_FFFF);
    offer_sample(2'd0, 1'b0, 20'h00100, 20'hFFF00);
    offer_sample(2'd1, 1'b0, 20'h7FFFF, 20'h7FFFF);
    offer_sample(2'd2, 1'b0, 20'h80000, 20'h80000);
    offer_sample(2'd3, 1'b0, 20'h12345, 20'hEDCBA);
    settle();

    // Gains near one keep the old value; zero inverse period kills the
    // derivative inputs. Upper write bits are set and must be dropped.
    write_all(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'h000000);
    offer_sample(2'd0, 1'b0, 20'h80000, 20'h7FFFF);
    offer_sample(2'd1, 1'b0, 20'h00000, 20'h00001);
    offer_sample(2'd2, 1'b1, 20'h55555, 20'hAAAAA);
    offer_sample(2'd3, 1'b0, 20'hAAAAA, 20'h55555);
    settle();

    // Smallest nonzero inverse period with tiny gains.
    write_all(24'h000001, 24'h000001, 24'h000001, 24'h000001);
    offer_sample(2'd0, 1'b0, 20'h00001, 20'hFFFFF);
    offer_sample(2'd1, 1'b1, 20'h7FFFF, 20'h80000);
    offer_sample(2'd1, 1'b0, 20'h80000, 20'h7FFFF);

    // Random phases, each with its own register setting and idle mix.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p == 0) begin
        write_all(GAIN_RESET, GAIN_RESET, GAIN_RESET, INV_PER_RESET);
      end else begin
        write_all(pick_gain(), pick_gain(), pick_gain(), pick_inv_period());
      end
      mode    = (p == 0) ? 0 : $urandom_range(0, 3);
      tx_idle = (mode == 1 || mode == 2);
      rx_idle = (mode == 1 || mode == 3);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        // back up the block: receiver holds off while words keep coming
        if (p == PHASES / 2 && i == PHASE_WORDS / 3) begin
          tx_idle      = 1'b0;
          hold_off_req = 1'b1;
        end
        random_sample();
      end
    end

    settle();
    $display("run: %0d sample words over %0d register settings, %0d results compared",
             words_sent, settings, model.checked);
    $display("run: %0d long receiver hold-offs, %0d mismatches", holds_done, model.errors);
    if (model.errors == 0 && model.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest correct run.
  initial begin
    #2_400_000;
    $display("run: timed out with %0d results outstanding", model.pending());
    $display("TB_ERROR");
    $finish;
  end

endmodule
